[hw/rtl/tgad_pkg.sv]
// Shared types and constants for the 16-bit true-color TGA decoder.
// Used by the parser, the work queue, the result sequencer and the top level.
package tgad_pkg;

	// Header layout (byte offsets within the 18-byte header).
	localparam int HDR_LEN       = 18;
	localparam int HDR_ID_LEN    = 0;
	localparam int HDR_CMAP_TYPE = 1;
	localparam int HDR_IMG_TYPE  = 2;
	localparam int HDR_CMAP_LEN0 = 5;
	localparam int HDR_CMAP_LEN1 = 6;
	localparam int HDR_WIDTH0    = 12;
	localparam int HDR_WIDTH1    = 13;
	localparam int HDR_HEIGHT0   = 14;
	localparam int HDR_HEIGHT1   = 15;
	localparam int HDR_DEPTH     = 16;

	// Accepted header values and descriptor bits.
	localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
	localparam logic [7:0] PIXEL_DEPTH_16     = 8'd16;
	localparam int DESC_RIGHT_TO_LEFT_BIT     = 4;
	localparam int DESC_TOP_ORIGIN_BIT        = 5;

	// Work queue depth between parser and result sequencer.
	localparam int QUEUE_DEPTH = 4;

	// Result kinds.
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Final status codes.
	typedef enum logic [3:0] {
		ST_OK            = 4'd0,
		ST_HEADER_SHORT  = 4'd1,
		ST_COLOR_MAP     = 4'd2,
		ST_NOT_TRUECOLOR = 4'd3,
		ST_NOT_16BIT     = 4'd4,
		ST_ZERO_SIZE     = 4'd5,
		ST_RIGHT_TO_LEFT = 4'd6,
		ST_TOO_LARGE     = 4'd7,
		ST_PAYLOAD_SHORT = 4'd8
	} tgad_status_t;

	// Work for one input beat: an optional pixel and an optional final status.
	typedef struct packed {
		logic         pix_valid;
		logic [14:0]  pix_value;
		logic [11:0]  pix_column;
		logic [11:0]  pix_row;
		logic         stat_valid;
		tgad_status_t stat_code;
	} tgad_work_t;

endpackage

[hw/rtl/tga16_truecolor_decoder_core.sv]
// Channel   Valid          Stall          Payload
// byte      byte_valid     byte_stall     file_byte, end_of_file
// result    result_valid   result_stall   result_kind, pixel_value, pixel_column,
//                                         pixel_row, status_code, last_result
//
// One byte beat is taken per clock; the parser never waits on itself, only on a full queue.
// Pixels pass the work queue and the output register; a final status follows its pixel.
// A final byte that completes a pixel yields two result beats, the pixel first.
// After reset the block takes bytes at once; the end-of-file beat returns it to the header.
// Result stalls back up through the output register and the four-entry work queue.
//
// Top level of the 16-bit true-color TGA decoder: parser, work queue and result sequencer.
// Depends on tgad_pkg, tgad_front, tgad_queue and tgad_back.
module tga16_truecolor_decoder_core #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  file_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        result_kind,
	output logic [14:0] pixel_value,
	output logic [11:0] pixel_column,
	output logic [11:0] pixel_row,
	output logic [3:0]  status_code,
	output logic        last_result
);
	import tgad_pkg::*;

	tgad_work_t push_work, pop_work;
	logic       push, queue_full, queue_valid, queue_pop;

	// Front: header, ID skip and pixel assembly.
	tgad_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.file_byte  (file_byte),
		.end_of_file(end_of_file),
		.byte_stall (byte_stall),
		.queue_full (queue_full),
		.push       (push),
		.work       (push_work)
	);

	// Queue between the two halves.
	tgad_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_work(push_work),
		.full     (queue_full),
		.pop      (queue_pop),
		.pop_valid(queue_valid),
		.pop_work (pop_work)
	);

	// Back: result beats.
	tgad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_valid (queue_valid),
		.queue_work  (pop_work),
		.queue_pop   (queue_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind (result_kind),
		.pixel_value (pixel_value),
		.pixel_column(pixel_column),
		.pixel_row   (pixel_row),
		.status_code (status_code),
		.last_result (last_result)
	);

endmodule

[hw/rtl/tgad_front.sv]
// Byte parser: latches and checks the header, skips the ID field and assembles pixels.
// Depends on tgad_pkg; pushes one work entry per productive beat into the work queue.
module tgad_front #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic [7:0]          file_byte,
	input  logic                end_of_file,
	output logic                byte_stall,
	input  logic                queue_full,
	output logic                push,
	output tgad_pkg::tgad_work_t work
);
	import tgad_pkg::*;

	localparam logic [15:0] MaxWidth  = 16'(MAX_WIDTH);
	localparam logic [15:0] MaxHeight = 16'(MAX_HEIGHT);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_TAIL,
		PH_BAD
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [4:0]   pos_q;
	logic [7:0]   id_len_q, cmap_type_q, img_type_q, cmap_len0_q, cmap_len1_q;
	logic [7:0]   width0_q, width1_q, height0_q, height1_q, depth_q;
	tgad_status_t bad_code_q, hdr_code, bad_code_d, stat_code;
	logic [7:0]   skip_q;
	logic [15:0]  img_w_q, img_h_q, col_q, frow_q, row_q;
	logic         top_q;
	logic [7:0]   low_q;
	logic         low_valid_q;
	logic         fire, hdr_done, pix_emit, last_col, last_row;
	logic [15:0]  hdr_w, hdr_h, col_next, frow_next;

	assign fire       = byte_valid && !byte_stall;
	assign byte_stall = queue_full;

	assign hdr_w     = {width1_q, width0_q};
	assign hdr_h     = {height1_q, height0_q};
	assign hdr_done  = (pos_q == 5'(HDR_LEN - 1));
	assign col_next  = col_q + 16'd1;
	assign frow_next = frow_q + 16'd1;
	assign last_col  = (col_next == img_w_q);
	assign last_row  = (frow_next == img_h_q);

	// Header check in priority order; the descriptor is the byte arriving now.
	always_comb begin
		priority if (cmap_type_q != 8'd0 || {cmap_len1_q, cmap_len0_q} != 16'd0) begin
			hdr_code = ST_COLOR_MAP;
		end else if (img_type_q != IMG_TYPE_TRUECOLOR) begin
			hdr_code = ST_NOT_TRUECOLOR;
		end else if (depth_q != PIXEL_DEPTH_16) begin
			hdr_code = ST_NOT_16BIT;
		end else if (hdr_w == 16'd0 || hdr_h == 16'd0) begin
			hdr_code = ST_ZERO_SIZE;
		end else if (file_byte[DESC_RIGHT_TO_LEFT_BIT]) begin
			hdr_code = ST_RIGHT_TO_LEFT;
		end else if (hdr_w > MaxWidth || hdr_h > MaxHeight) begin
			hdr_code = ST_TOO_LARGE;
		end else begin
			hdr_code = ST_OK;
		end
	end

	// Next phase and whether this beat completes a pixel.
	always_comb begin
		phase_d  = phase_q;
		pix_emit = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_done) begin
					if (hdr_code != ST_OK) begin
						phase_d = PH_BAD;
					end else begin
						phase_d = (id_len_q != 8'd0) ? PH_SKIP : PH_PIXELS;
					end
				end
			end
			PH_SKIP: begin
				if (skip_q == 8'd1) begin
					phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (low_valid_q) begin
					pix_emit = 1'b1;
					if (last_col && last_row) begin
						phase_d = PH_TAIL;
					end
				end
			end
			PH_TAIL, PH_BAD: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// Final status follows the phase reached after this beat.
	assign bad_code_d = (phase_q == PH_HEADER) ? hdr_code : bad_code_q;
	always_comb begin
		unique case (phase_d)
			PH_HEADER: stat_code = ST_HEADER_SHORT;
			PH_BAD:    stat_code = bad_code_d;
			PH_TAIL:   stat_code = ST_OK;
			default:   stat_code = ST_PAYLOAD_SHORT;
		endcase
	end

	// Work entry toward the result sequencer.
	always_comb begin
		work.pix_valid  = pix_emit;
		work.pix_value  = {file_byte[6:0], low_q};
		work.pix_column = col_q[11:0];
		work.pix_row    = row_q[11:0];
		work.stat_valid = end_of_file;
		work.stat_code  = stat_code;
	end
	assign push = fire && (pix_emit || end_of_file);

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			id_len_q    <= '0;
			cmap_type_q <= '0;
			img_type_q  <= '0;
			cmap_len0_q <= '0;
			cmap_len1_q <= '0;
			width0_q    <= '0;
			width1_q    <= '0;
			height0_q   <= '0;
			height1_q   <= '0;
			depth_q     <= '0;
			bad_code_q  <= ST_OK;
			skip_q      <= '0;
			img_w_q     <= '0;
			img_h_q     <= '0;
			top_q       <= 1'b0;
			col_q       <= '0;
			frow_q      <= '0;
			row_q       <= '0;
			low_q       <= '0;
			low_valid_q <= 1'b0;
		end else if (fire) begin
			if (end_of_file) begin
				phase_q     <= PH_HEADER;
				pos_q       <= '0;
				low_valid_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				unique case (phase_q)
					PH_HEADER: begin
						pos_q <= pos_q + 5'd1;
						if (pos_q == 5'(HDR_ID_LEN))    id_len_q    <= file_byte;
						if (pos_q == 5'(HDR_CMAP_TYPE)) cmap_type_q <= file_byte;
						if (pos_q == 5'(HDR_IMG_TYPE))  img_type_q  <= file_byte;
						if (pos_q == 5'(HDR_CMAP_LEN0)) cmap_len0_q <= file_byte;
						if (pos_q == 5'(HDR_CMAP_LEN1)) cmap_len1_q <= file_byte;
						if (pos_q == 5'(HDR_WIDTH0))    width0_q    <= file_byte;
						if (pos_q == 5'(HDR_WIDTH1))    width1_q    <= file_byte;
						if (pos_q == 5'(HDR_HEIGHT0))   height0_q   <= file_byte;
						if (pos_q == 5'(HDR_HEIGHT1))   height1_q   <= file_byte;
						if (pos_q == 5'(HDR_DEPTH))     depth_q     <= file_byte;
						if (hdr_done) begin
							bad_code_q  <= hdr_code;
							skip_q      <= id_len_q;
							img_w_q     <= hdr_w;
							img_h_q     <= hdr_h;
							top_q       <= file_byte[DESC_TOP_ORIGIN_BIT];
							col_q       <= '0;
							frow_q      <= '0;
							row_q       <= file_byte[DESC_TOP_ORIGIN_BIT] ? 16'd0
							                                              : hdr_h - 16'd1;
							low_valid_q <= 1'b0;
						end
					end
					PH_SKIP: begin
						skip_q <= skip_q - 8'd1;
					end
					PH_PIXELS: begin
						if (low_valid_q) begin
							low_valid_q <= 1'b0;
							if (last_col) begin
								col_q  <= '0;
								frow_q <= frow_next;
								row_q  <= top_q ? row_q + 16'd1 : row_q - 16'd1;
							end else begin
								col_q <= col_next;
							end
						end else begin
							low_q       <= file_byte;
							low_valid_q <= 1'b1;
						end
					end
					default: begin
						low_valid_q <= low_valid_q;
					end
				endcase
			end
		end
	end

endmodule

[hw/rtl/tgad_queue.sv]
// Short work queue that decouples the byte parser from the result sequencer.
// Depends on tgad_pkg for the work entry type and the queue depth.
module tgad_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tgad_pkg::tgad_work_t push_work,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output tgad_pkg::tgad_work_t pop_work
);
	import tgad_pkg::*;

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	tgad_work_t        slots_q [QUEUE_DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full      = (count_q == CntW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_work  = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_work;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	// The parser never writes a full queue and the sequencer never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("work queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("work queue read while empty");

endmodule

[hw/rtl/tgad_back.sv]
// Result sequencer: turns work entries into pixel and status beats on the output register.
// Depends on tgad_pkg; an entry with both a pixel and a status takes two beats.
module tgad_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 queue_valid,
	input  tgad_pkg::tgad_work_t queue_work,
	output logic                 queue_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 result_kind,
	output logic [14:0]          pixel_value,
	output logic [11:0]          pixel_column,
	output logic [11:0]          pixel_row,
	output logic [3:0]           status_code,
	output logic                 last_result
);
	import tgad_pkg::*;

	logic         valid_q, kind_q, last_q;
	logic [14:0]  value_q;
	logic [11:0]  column_q, row_q;
	tgad_status_t code_q, pend_code_q;
	logic         pend_q;
	logic         load;

	assign load      = !valid_q || !result_stall;
	assign queue_pop = load && !pend_q && queue_valid;

	assign result_valid = valid_q;
	assign result_kind  = kind_q;
	assign pixel_value  = value_q;
	assign pixel_column = column_q;
	assign pixel_row    = row_q;
	assign status_code  = code_q;
	assign last_result  = last_q;

	// Output register; a held status goes out right after its pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			kind_q      <= KIND_PIXEL;
			last_q      <= 1'b0;
			value_q     <= '0;
			column_q    <= '0;
			row_q       <= '0;
			code_q      <= ST_OK;
			pend_q      <= 1'b0;
			pend_code_q <= ST_OK;
		end else if (load) begin
			if (pend_q) begin
				valid_q  <= 1'b1;
				kind_q   <= KIND_STATUS;
				last_q   <= 1'b1;
				value_q  <= '0;
				column_q <= '0;
				row_q    <= '0;
				code_q   <= pend_code_q;
				pend_q   <= 1'b0;
			end else if (queue_valid) begin
				valid_q <= 1'b1;
				if (queue_work.pix_valid) begin
					kind_q      <= KIND_PIXEL;
					last_q      <= 1'b0;
					value_q     <= queue_work.pix_value;
					column_q    <= queue_work.pix_column;
					row_q       <= queue_work.pix_row;
					code_q      <= ST_OK;
					pend_q      <= queue_work.stat_valid;
					pend_code_q <= queue_work.stat_code;
				end else begin
					kind_q   <= KIND_STATUS;
					last_q   <= 1'b1;
					value_q  <= '0;
					column_q <= '0;
					row_q    <= '0;
					code_q   <= queue_work.stat_code;
				end
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// A held status only exists behind a pixel beat that is still on the output.
	a_pend_behind_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (valid_q && kind_q == KIND_PIXEL))
		else $error("status held without a pixel in the output register");
	// When that pixel beat is taken, the next beat is the final status.
	a_pend_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_stall && pend_q) |=> (valid_q && kind_q == KIND_STATUS && last_q))
		else $error("held status did not follow its pixel");

endmodule

[tb/tb_tga16_truecolor_decoder_core.sv]
// Self-checking testbench for tga16_truecolor_decoder_core: streams TGA files byte by byte
// and checks every pixel and status beat against a built-in decoder of its own.
// Depends on tgad_pkg and the RTL of the decoder core.
`timescale 1ns / 1ps

module tb_tga16_truecolor_decoder_core;
	import tgad_pkg::*;

	localparam int unsigned IMG_MAX_WIDTH  = 4096;
	localparam int unsigned IMG_MAX_HEIGHT = 4096;
	localparam int HDR_DESCRIPTOR = 17;
	localparam int STREAM_BYTES   = 550;
	localparam int CALM_BYTES     = 80;
	localparam int PRESSURE_AFTER = 30;
	localparam int PRESSURE_HOLD  = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int LIMIT_CYCLES   = 200000;

	typedef enum {DEC_HEADER, DEC_ID_SKIP, DEC_PIXELS, DEC_TAIL, DEC_BAD} decode_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eof;
	} file_beat_t;

	typedef struct {
		logic         kind;
		logic [14:0]  value;
		logic [11:0]  column;
		logic [11:0]  row;
		tgad_status_t code;
		logic         last;
	} decoded_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  file_byte = 8'h00;
	logic        end_of_file = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        result_kind;
	logic [14:0] pixel_value;
	logic [11:0] pixel_column;
	logic [11:0] pixel_row;
	logic [3:0]  status_code;
	logic        last_result;

	// Stimulus and expectations.
	logic [7:0]    file_buf[$];
	file_beat_t    file_stream[$];
	decoded_beat_t pixel_status_queue[$];
	int            bytes_total = 0;
	int            bytes_accepted = 0;
	int            results_checked = 0;
	int            error_count = 0;
	int            cycle_count = 0;

	// Decoder state as the design should hold it.
	decode_phase_t dec_phase = DEC_HEADER;
	logic [7:0]    hdr_bytes[HDR_LEN];
	int            hdr_pos = 0;
	tgad_status_t  bad_code = ST_OK;
	int unsigned   skip_left = 0;
	int unsigned   img_w = 0;
	int unsigned   img_h = 0;
	logic          top_first = 1'b0;
	int unsigned   col = 0;
	int unsigned   frow = 0;
	logic [7:0]    low_byte = 8'h00;
	logic          low_valid = 1'b0;

	// Handshake bookkeeping for both sides.
	logic byte_taken = 1'b0;
	int   send_gap = 0;
	int   send_quiet = 0;
	int   stall_left = 0;
	int   recv_quiet = 0;
	int   hold_left = 0;
	bit   pressure_done = 1'b0;

	tga16_truecolor_decoder_core #(
		.MAX_WIDTH(IMG_MAX_WIDTH),
		.MAX_HEIGHT(IMG_MAX_HEIGHT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.file_byte(file_byte),
		.end_of_file(end_of_file),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind(result_kind),
		.pixel_value(pixel_value),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.status_code(status_code),
		.last_result(last_result)
	);

	always #5 clk = ~clk;

	// Advances the decoder by one file byte and queues the beats it should produce.
	function automatic void decode_byte(input logic [7:0] data, input logic eof);
		logic [15:0]  word;
		int unsigned  row;
		tgad_status_t code;
		unique case (dec_phase)
		DEC_HEADER: begin
			hdr_bytes[hdr_pos] = data;
			hdr_pos++;
			if (hdr_pos == HDR_LEN) begin
				img_w = 32'({hdr_bytes[HDR_WIDTH1], hdr_bytes[HDR_WIDTH0]});
				img_h = 32'({hdr_bytes[HDR_HEIGHT1], hdr_bytes[HDR_HEIGHT0]});
				top_first = hdr_bytes[HDR_DESCRIPTOR][DESC_TOP_ORIGIN_BIT];
				// Header checks in their order of priority.
				if (hdr_bytes[HDR_CMAP_TYPE] != 8'd0 || hdr_bytes[HDR_CMAP_LEN0] != 8'd0 ||
						hdr_bytes[HDR_CMAP_LEN1] != 8'd0)
					code = ST_COLOR_MAP;
				else if (hdr_bytes[HDR_IMG_TYPE] != IMG_TYPE_TRUECOLOR)
					code = ST_NOT_TRUECOLOR;
				else if (hdr_bytes[HDR_DEPTH] != PIXEL_DEPTH_16)
					code = ST_NOT_16BIT;
				else if (img_w == 0 || img_h == 0)
					code = ST_ZERO_SIZE;
				else if (hdr_bytes[HDR_DESCRIPTOR][DESC_RIGHT_TO_LEFT_BIT])
					code = ST_RIGHT_TO_LEFT;
				else if (img_w > IMG_MAX_WIDTH || img_h > IMG_MAX_HEIGHT)
					code = ST_TOO_LARGE;
				else
					code = ST_OK;
				if (code != ST_OK) begin
					bad_code = code;
					dec_phase = DEC_BAD;
				end else begin
					skip_left = 32'(hdr_bytes[HDR_ID_LEN]);
					col = 0;
					frow = 0;
					low_valid = 1'b0;
					dec_phase = (skip_left != 0) ? DEC_ID_SKIP : DEC_PIXELS;
				end
			end
		end
		DEC_ID_SKIP: begin
			skip_left--;
			if (skip_left == 0)
				dec_phase = DEC_PIXELS;
		end
		DEC_PIXELS: begin
			if (low_valid) begin
				// High byte completes a little-endian pixel word.
				word = {data, low_byte};
				row = top_first ? frow : img_h - 1 - frow;
				pixel_status_queue.push_back('{KIND_PIXEL, word[14:0], col[11:0], row[11:0],
					ST_OK, 1'b0});
				low_valid = 1'b0;
				col++;
				if (col >= img_w) begin
					col = 0;
					frow++;
					if (frow >= img_h)
						dec_phase = DEC_TAIL;
				end
			end else begin
				low_byte = data;
				low_valid = 1'b1;
			end
		end
		default: ;
		endcase

		// The final byte reports the file status and rearms the header parser.
		if (eof) begin
			unique case (dec_phase)
			DEC_HEADER: code = ST_HEADER_SHORT;
			DEC_BAD:    code = bad_code;
			DEC_TAIL:   code = ST_OK;
			default:    code = ST_PAYLOAD_SHORT;
			endcase
			pixel_status_queue.push_back('{KIND_STATUS, 15'd0, 12'd0, 12'd0, code, 1'b1});
			hdr_pos = 0;
			low_valid = 1'b0;
			dec_phase = DEC_HEADER;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			error_count++;
		end
	endfunction

	function automatic bit late_in_run();
		return file_stream.size() < CALM_BYTES;
	endfunction

	// Starts a well-formed header; callers corrupt it as needed.
	task automatic build_header(input int unsigned id_len, input int unsigned w,
			input int unsigned h, input logic [7:0] desc);
		file_buf.delete();
		for (int i = 0; i < HDR_LEN; i++)
			file_buf.push_back(8'($urandom_range(0, 255)));
		file_buf[HDR_ID_LEN] = 8'(id_len);
		file_buf[HDR_CMAP_TYPE] = 8'h00;
		file_buf[HDR_IMG_TYPE] = IMG_TYPE_TRUECOLOR;
		file_buf[HDR_CMAP_LEN0] = 8'h00;
		file_buf[HDR_CMAP_LEN1] = 8'h00;
		file_buf[HDR_WIDTH0] = w[7:0];
		file_buf[HDR_WIDTH1] = w[15:8];
		file_buf[HDR_HEIGHT0] = h[7:0];
		file_buf[HDR_HEIGHT1] = h[15:8];
		file_buf[HDR_DEPTH] = PIXEL_DEPTH_16;
		file_buf[HDR_DESCRIPTOR] = desc;
	endtask

	// Queues the first cut bytes of the buffered file, flagging the last one.
	task automatic send_file(input int cut);
		for (int i = 0; i < cut; i++)
			file_stream.push_back('{data: file_buf[i], eof: (i == cut - 1)});
	endtask

	task automatic add_random_file();
		int unsigned kind;
		int unsigned w;
		int unsigned h;
		int unsigned id_len;
		int unsigned n_pay;
		int          cut;
		bit          big;
		logic [7:0]  desc;
		logic [15:0] size_val;
		tgad_status_t flaw;
		kind = $urandom_range(0, 99);
		w = $urandom_range(1, 4);
		h = $urandom_range(1, 4);
		if ($urandom_range(0, 19) == 0) begin
			if ($urandom_range(0, 1))
				w = IMG_MAX_WIDTH;
			else
				h = IMG_MAX_HEIGHT;
		end
		big = (w * h > 16);
		id_len = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 3);
		desc = 8'($urandom_range(0, 255));
		desc[DESC_RIGHT_TO_LEFT_BIT] = 1'b0;
		build_header(id_len, w, h, desc);

		if (kind >= 90) begin
			// Pure noise, mostly rejected headers or short files.
			file_buf.delete();
			cut = $urandom_range(1, 40);
			repeat (cut) file_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind >= 70) begin
			// One deliberate header fault, then a few stray bytes.
			flaw = tgad_status_t'($urandom_range(ST_COLOR_MAP, ST_TOO_LARGE));
			size_val = 16'($urandom_range(IMG_MAX_WIDTH + 1, 65535));
			unique case (flaw)
			ST_COLOR_MAP: begin
				if ($urandom_range(0, 1))
					file_buf[HDR_CMAP_TYPE] = 8'($urandom_range(1, 255));
				else
					file_buf[HDR_CMAP_LEN0 + $urandom_range(0, 1)] =
						8'($urandom_range(1, 255));
			end
			ST_NOT_TRUECOLOR: file_buf[HDR_IMG_TYPE] ^= 8'($urandom_range(1, 255));
			ST_NOT_16BIT:     file_buf[HDR_DEPTH] ^= 8'($urandom_range(1, 255));
			ST_ZERO_SIZE: begin
				if ($urandom_range(0, 1)) begin
					file_buf[HDR_WIDTH0] = 8'h00;
					file_buf[HDR_WIDTH1] = 8'h00;
				end else begin
					file_buf[HDR_HEIGHT0] = 8'h00;
					file_buf[HDR_HEIGHT1] = 8'h00;
				end
			end
			ST_RIGHT_TO_LEFT: file_buf[HDR_DESCRIPTOR][DESC_RIGHT_TO_LEFT_BIT] = 1'b1;
			ST_TOO_LARGE: begin
				if ($urandom_range(0, 1)) begin
					file_buf[HDR_WIDTH0] = size_val[7:0];
					file_buf[HDR_WIDTH1] = size_val[15:8];
				end else begin
					file_buf[HDR_HEIGHT0] = size_val[7:0];
					file_buf[HDR_HEIGHT1] = size_val[15:8];
				end
			end
			default: ;
			endcase
			repeat ($urandom_range(0, 4)) file_buf.push_back(8'($urandom_range(0, 255)));
			cut = file_buf.size();
		end else begin
			// Valid header, ID field and pixel data, maybe cut short; large images stay truncated.
			n_pay = big ? 24 : 2 * w * h;
			repeat (id_len + n_pay) file_buf.push_back(8'($urandom_range(0, 255)));
			if (kind >= 65) begin
				cut = $urandom_range(1, HDR_LEN - 1);
			end else if (kind >= 55) begin
				cut = $urandom_range(HDR_LEN, file_buf.size() - 1);
			end else begin
				if (!big)
					repeat ($urandom_range(0, 2))
						file_buf.push_back(8'($urandom_range(0, 255)));
				cut = file_buf.size();
			end
		end
		send_file(cut);
	endtask

	// Byte side: capture accepted beats at the rising edge and predict their results.
	always @(posedge clk) begin : byte_capture
		if (arst_n && byte_valid && !byte_stall) begin
			decode_byte(file_byte, end_of_file);
			bytes_accepted++;
			byte_taken <= 1'b1;
		end else begin
			byte_taken <= 1'b0;
		end
	end

	// Byte side: present the next beat at the falling edge, with random idle bursts.
	always @(negedge clk) begin : byte_driver
		file_beat_t next_beat;
		if (arst_n && (!byte_valid || byte_taken)) begin
			if (send_quiet > 0)
				send_quiet--;
			else if (!late_in_run() && $urandom_range(0, 39) == 0)
				send_quiet = $urandom_range(10, 40);

			if (send_gap > 0) begin
				byte_valid <= 1'b0;
				send_gap--;
			end else if (file_stream.size() == 0) begin
				byte_valid <= 1'b0;
			end else if (!late_in_run() && send_quiet == 0 && $urandom_range(0, 4) == 0) begin
				byte_valid <= 1'b0;
				send_gap = $urandom_range(0, 3);
			end else begin
				next_beat = file_stream.pop_front();
				byte_valid <= 1'b1;
				file_byte <= next_beat.data;
				end_of_file <= next_beat.eof;
			end
		end
	end

	// Result side: random stall bursts, plus one long hold-off to back up the pipeline.
	always @(negedge clk) begin : result_receiver
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (!pressure_done && results_checked >= PRESSURE_AFTER) begin
			pressure_done = 1'b1;
			hold_left = PRESSURE_HOLD - 1;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			if (recv_quiet > 0)
				recv_quiet--;
			else if (!late_in_run() && $urandom_range(0, 39) == 0)
				recv_quiet = $urandom_range(10, 40);
			if (!late_in_run() && recv_quiet == 0 && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Result side: compare each accepted beat with the oldest prediction.
	always @(posedge clk) begin : result_monitor
		decoded_beat_t want;
		if (arst_n && result_valid !== 1'b0 && result_stall == 1'b0) begin
			if (pixel_status_queue.size() == 0) begin
				$error("result beat with nothing predicted: kind %0h status %0h",
					result_kind, status_code);
				error_count++;
			end else begin
				want = pixel_status_queue.pop_front();
				check_field("result_kind", 32'(want.kind), 32'(result_kind));
				check_field("pixel_value", 32'(want.value), 32'(pixel_value));
				check_field("pixel_column", 32'(want.column), 32'(pixel_column));
				check_field("pixel_row", 32'(want.row), 32'(pixel_row));
				check_field("status_code", 32'(want.code), 32'(status_code));
				check_field("last_result", 32'(want.last), 32'(last_result));
			end
			results_checked++;
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		// Directed files: a one-byte file, then a 1x1 top-origin image of all ones.
		file_buf.delete();
		file_buf.push_back(8'hff);
		send_file(1);
		build_header(0, 1, 1, 8'h20);
		file_buf.push_back(8'hff);
		file_buf.push_back(8'hff);
		send_file(file_buf.size());

		while (file_stream.size() < STREAM_BYTES)
			add_random_file();
		bytes_total = file_stream.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: all bytes taken, all predictions met, then a short quiet period.
		while (bytes_accepted < bytes_total)
			@(posedge clk);
		while (pixel_status_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pixel_status_queue.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/tgad_pkg.sv
hw/rtl/tgad_front.sv
hw/rtl/tgad_queue.sv
hw/rtl/tgad_back.sv
hw/rtl/tga16_truecolor_decoder_core.sv
tb/tb_tga16_truecolor_decoder_core.sv
